[rtl/core/ppe_pkg.sv]
// Shared types and constants for the PIN-guarded purse engine.
package ppe_pkg;

  // Widest secrets the engine supports; narrower ones travel zero-extended.
  localparam int PIN_MAX_W = 64;
  localparam int PUK_MAX_W = 64;

  localparam logic [3:0] PIN_TRIES_RESET = 4'd3;
  localparam logic [3:0] PUK_TRIES_RESET = 4'd5;

  localparam logic [7:0] PUK_DIGIT_RESET = 8'h39;

  // Configuration register indexes (byte address / 8).
  localparam logic [1:0] REG_PUK_CODE      = 2'd0;
  localparam logic [1:0] REG_PIN_TRY_LIMIT = 2'd1;
  localparam logic [1:0] REG_PUK_TRY_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    OP_READ_BAL  = 3'd0,
    OP_CREDIT    = 3'd1,
    OP_DEBIT     = 3'd2,
    OP_VERIFY    = 3'd3,
    OP_CHANGE    = 3'd4,
    OP_PUK_RESET = 3'd5,
    OP_READ_CTR  = 3'd6,
    OP_INVALID   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_SECRET  = 3'd3,
    ST_NOTVER  = 3'd4,
    ST_REPLAY  = 3'd5,
    ST_AMOUNT  = 3'd6
  } status_t;

  // A classified command as it waits for the executor.
  typedef struct packed {
    op_t                  op;
    logic                 len_ok;
    logic [4:0]           need;
    logic [15:0]          replay_count_in;
    logic [15:0]          amount;
    logic [PIN_MAX_W-1:0] pin_entered;
    logic [PIN_MAX_W-1:0] pin_new;
    logic [PUK_MAX_W-1:0] puk_entered;
  } cmd_entry_t;

  // Factory PIN: bytes 1, 2, 3 ... from the top byte down.
  function automatic logic [PIN_MAX_W-1:0] pin_reset_value(input int bytes);
    logic [PIN_MAX_W-1:0] v;
    v = '0;
    for (int i = 0; i < bytes; i++) begin
      v = {v[PIN_MAX_W-9:0], 8'(i + 1)};
    end
    return v;
  endfunction

endpackage

[rtl/core/ppe_channels.sv]
// Valid/ready channel interfaces for command and response beats.
interface ppe_cmd_if #(
  parameter int PIN_W = 32,
  parameter int PUK_W = 48
);
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [7:0]       length_byte;
  logic [15:0]      replay_count_in;
  logic [15:0]      amount;
  logic [PIN_W-1:0] pin_entered;
  logic [PIN_W-1:0] pin_new;
  logic [PUK_W-1:0] puk_entered;

  modport source (
    output valid, action, length_byte, replay_count_in, amount,
           pin_entered, pin_new, puk_entered,
    input  ready
  );
  modport sink (
    input  valid, action, length_byte, replay_count_in, amount,
           pin_entered, pin_new, puk_entered,
    output ready
  );
endinterface

interface ppe_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  detail;
  logic [15:0] read_data;

  modport source (output valid, status, detail, read_data, input ready);
  modport sink   (input  valid, status, detail, read_data, output ready);
endinterface

[rtl/core/ppe_front.sv]
// Front end: accept a command beat, decode the action and check its length.
module ppe_front #(
  parameter int PIN_BYTES = 4,
  parameter int PUK_BYTES = 6
) (
  input  logic               clk,
  input  logic               rst,
  ppe_cmd_if.sink            cmd,
  output logic               f_valid,
  input  logic               f_ready,
  output ppe_pkg::cmd_entry_t f_entry
);

  localparam logic [4:0] NEED_SHORT  = 5'd2;
  localparam logic [4:0] NEED_VERIFY = 5'(PIN_BYTES);
  localparam logic [4:0] NEED_CHANGE = 5'(2 * PIN_BYTES);
  localparam logic [4:0] NEED_PUK    = 5'(PUK_BYTES + PIN_BYTES);

  ppe_pkg::cmd_entry_t entry_next;
  ppe_pkg::op_t        op;
  logic [4:0]          need;
  logic                len_ok;

  assign cmd.ready = !f_valid || f_ready;
  assign op        = ppe_pkg::op_t'(cmd.action);

  always_comb begin
    need   = NEED_SHORT;
    len_ok = 1'b1;
    case (op)
      ppe_pkg::OP_READ_BAL, ppe_pkg::OP_CREDIT,
      ppe_pkg::OP_DEBIT, ppe_pkg::OP_READ_CTR: need = NEED_SHORT;
      ppe_pkg::OP_VERIFY:    need = NEED_VERIFY;
      ppe_pkg::OP_CHANGE:    need = NEED_CHANGE;
      ppe_pkg::OP_PUK_RESET: need = NEED_PUK;
      default: begin
        need   = 5'd0;
        len_ok = 1'b0;
      end
    endcase
    if (cmd.length_byte != {3'b000, need}) begin
      len_ok = 1'b0;
    end
  end

  always_comb begin
    entry_next.op              = op;
    entry_next.len_ok          = len_ok;
    entry_next.need            = need;
    entry_next.replay_count_in = cmd.replay_count_in;
    entry_next.amount          = cmd.amount;
    entry_next.pin_entered     = ppe_pkg::PIN_MAX_W'(cmd.pin_entered);
    entry_next.pin_new         = ppe_pkg::PIN_MAX_W'(cmd.pin_new);
    entry_next.puk_entered     = ppe_pkg::PUK_MAX_W'(cmd.puk_entered);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd.ready) begin
      f_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      f_entry <= entry_next;
    end
  end

endmodule

[rtl/core/ppe_queue.sv]
// Two-entry queue between the decoder and the executor.
module ppe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ppe_pkg::cmd_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop,
  output ppe_pkg::cmd_entry_t pop_entry
);

  ppe_pkg::cmd_entry_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/core/ppe_exec.sv]
// Executor: run one command against the card state and register its answer.
module ppe_exec #(
  parameter int PIN_BYTES = 4,
  parameter int PUK_BYTES = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  ppe_pkg::cmd_entry_t      q_entry,
  input  logic [8*PUK_BYTES-1:0]   puk_code,
  input  logic [3:0]               pin_try_limit,
  input  logic [3:0]               puk_try_limit,
  ppe_rsp_if.source                rsp
);

  localparam int PIN_W = 8 * PIN_BYTES;
  localparam int PUK_W = 8 * PUK_BYTES;
  localparam logic [PIN_W-1:0] PIN_RESET =
    PIN_W'(ppe_pkg::pin_reset_value(PIN_BYTES));

  logic [PIN_W-1:0] stored_pin, stored_pin_next;
  logic [3:0]       pin_tries_left, pin_tries_left_next;
  logic [3:0]       puk_tries_left, puk_tries_left_next;
  logic             pin_verified, pin_verified_next;
  logic [15:0]      balance, balance_next;
  logic [15:0]      replay_counter, replay_counter_next;

  logic             out_valid;
  ppe_pkg::status_t out_status, status_next;
  logic [4:0]       out_detail, detail_next;
  logic [15:0]      out_data, data_next;

  logic [16:0]      sum;
  logic [3:0]       pin_dec;
  logic [3:0]       puk_dec;
  logic             pin_match;
  logic             puk_match;

  assign q_pop         = q_valid && (!out_valid || rsp.ready);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.detail    = out_detail;
  assign rsp.read_data = out_data;

  assign sum       = {1'b0, balance} + {1'b0, q_entry.amount};
  assign pin_dec   = pin_tries_left - 4'd1;
  assign puk_dec   = puk_tries_left - 4'd1;
  assign pin_match = (q_entry.pin_entered[PIN_W-1:0] == stored_pin);
  assign puk_match = (q_entry.puk_entered[PUK_W-1:0] == puk_code);

  always_comb begin
    stored_pin_next     = stored_pin;
    pin_tries_left_next = pin_tries_left;
    puk_tries_left_next = puk_tries_left;
    pin_verified_next   = pin_verified;
    balance_next        = balance;
    replay_counter_next = replay_counter;
    status_next         = ppe_pkg::ST_OK;
    detail_next         = 5'd0;
    data_next           = 16'd0;
    case (q_entry.op)
      ppe_pkg::OP_READ_BAL: begin
        if (!pin_verified) begin
          status_next = ppe_pkg::ST_NOTVER;
        end else if (!q_entry.len_ok) begin
          status_next = ppe_pkg::ST_LENGTH;
          detail_next = q_entry.need;
        end else begin
          data_next = balance;
        end
      end
      ppe_pkg::OP_CREDIT, ppe_pkg::OP_DEBIT: begin
        if (!pin_verified) begin
          status_next = ppe_pkg::ST_NOTVER;
        end else if (q_entry.replay_count_in != replay_counter) begin
          status_next = ppe_pkg::ST_REPLAY;
        end else begin
          replay_counter_next = replay_counter + 16'd1;
          if (!q_entry.len_ok) begin
            status_next = ppe_pkg::ST_LENGTH;
            detail_next = q_entry.need;
          end else if (q_entry.op == ppe_pkg::OP_CREDIT) begin
            if (sum[16]) begin
              status_next = ppe_pkg::ST_AMOUNT;
            end else begin
              balance_next = sum[15:0];
            end
          end else if (q_entry.amount > balance) begin
            status_next = ppe_pkg::ST_AMOUNT;
          end else begin
            balance_next = balance - q_entry.amount;
          end
        end
      end
      ppe_pkg::OP_VERIFY, ppe_pkg::OP_CHANGE: begin
        if (pin_tries_left == 4'd0) begin
          status_next = ppe_pkg::ST_BLOCKED;
        end else if (!q_entry.len_ok) begin
          status_next = ppe_pkg::ST_LENGTH;
          detail_next = q_entry.need;
        end else if (!pin_match) begin
          pin_verified_next   = 1'b0;
          pin_tries_left_next = pin_dec;
          if (pin_dec == 4'd0) begin
            status_next = ppe_pkg::ST_BLOCKED;
          end else begin
            status_next = ppe_pkg::ST_SECRET;
            detail_next = {1'b0, pin_dec};
          end
        end else begin
          if (q_entry.op == ppe_pkg::OP_CHANGE) begin
            stored_pin_next = q_entry.pin_new[PIN_W-1:0];
          end
          pin_verified_next   = 1'b1;
          pin_tries_left_next = pin_try_limit;
        end
      end
      ppe_pkg::OP_PUK_RESET: begin
        if (puk_tries_left == 4'd0) begin
          status_next = ppe_pkg::ST_BLOCKED;
        end else if (!q_entry.len_ok) begin
          status_next = ppe_pkg::ST_LENGTH;
          detail_next = q_entry.need;
        end else if (!puk_match) begin
          puk_tries_left_next = puk_dec;
          if (puk_dec == 4'd0) begin
            status_next = ppe_pkg::ST_BLOCKED;
          end else begin
            status_next = ppe_pkg::ST_SECRET;
            detail_next = {1'b0, puk_dec};
          end
        end else begin
          stored_pin_next     = q_entry.pin_new[PIN_W-1:0];
          pin_tries_left_next = pin_try_limit;
          puk_tries_left_next = puk_try_limit;
          pin_verified_next   = 1'b1;
        end
      end
      ppe_pkg::OP_READ_CTR: begin
        if (!q_entry.len_ok) begin
          status_next = ppe_pkg::ST_LENGTH;
          detail_next = q_entry.need;
        end else begin
          data_next = replay_counter;
        end
      end
      default: begin
        status_next = ppe_pkg::ST_LENGTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_pin     <= PIN_RESET;
      pin_tries_left <= ppe_pkg::PIN_TRIES_RESET;
      puk_tries_left <= ppe_pkg::PUK_TRIES_RESET;
      pin_verified   <= 1'b0;
      balance        <= 16'd0;
      replay_counter <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        stored_pin     <= stored_pin_next;
        pin_tries_left <= pin_tries_left_next;
        puk_tries_left <= puk_tries_left_next;
        pin_verified   <= pin_verified_next;
        balance        <= balance_next;
        replay_counter <= replay_counter_next;
        out_valid      <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_status <= status_next;
      out_detail <= detail_next;
      out_data   <= data_next;
    end
  end

  a_ok_secret_sets_session: assert property (@(posedge clk) disable iff (rst)
    q_pop && status_next == ppe_pkg::ST_OK &&
    (q_entry.op == ppe_pkg::OP_VERIFY || q_entry.op == ppe_pkg::OP_CHANGE ||
     q_entry.op == ppe_pkg::OP_PUK_RESET) |=> pin_verified)
    else $error("session flag not set after accepted secret");

  a_secret_has_tries: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ppe_pkg::ST_SECRET |-> out_detail != 5'd0)
    else $error("wrong-secret answer without tries left");

  a_data_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data != 16'd0 |-> out_status == ppe_pkg::ST_OK)
    else $error("read data returned on a failed command");

  a_balance_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> $stable(balance) && $stable(replay_counter))
    else $error("purse state moved without a command");

endmodule

[rtl/core/pin_guarded_purse_engine.sv]
// Top level of the PIN-guarded purse engine: channels, register port, core.
//
// The engine executes card commands (read balance, credit, debit, verify PIN,
// change PIN, PIN reset by PUK, read replay counter) against a stored PIN,
// PIN and PUK try counters, a session-verified flag, a 16-bit balance and a
// 16-bit anti-replay counter. Each command beat on cmd yields exactly one
// response beat on rsp carrying a status, a detail value (expected length or
// tries left) and read data. Commands are taken one per clock cycle when the
// response side keeps up; an accepted beat passes through the decode register,
// then a queue slot, then the result register, and the executor, which
// updates all card state in one step per command, sets the sustained rate of
// one command per cycle while the response side keeps up. A two-entry queue
// between decoder and executor lets either side stall on its own; the result
// register holds a waiting response, and the executor takes no new command
// until that response is accepted.
// Registers sit on an APB-style port with 64-bit data at byte addresses
// 0 (PUK code), 8 (PIN try limit) and 16 (PUK try limit), with the low three
// address bits ignored; writes to addresses 24 to 31 are dropped and read back
// as zero. Write registers only while no command is in flight.
module pin_guarded_purse_engine #(
  parameter int PIN_BYTES = 4,
  parameter int PUK_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  ppe_cmd_if.sink     cmd,
  ppe_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PUK_W = 8 * PUK_BYTES;

  // Register file.
  logic [PUK_W-1:0] puk_code;
  logic [3:0]       pin_try_limit;
  logic [3:0]       puk_try_limit;
  logic [1:0]       reg_index;
  logic             reg_write;

  // Decoder to queue, queue to executor.
  logic                f_valid;
  logic                f_ready;
  ppe_pkg::cmd_entry_t f_entry;
  logic                q_valid;
  logic                q_pop;
  ppe_pkg::cmd_entry_t q_entry;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign reg_write = psel && penable && pwrite && pready;

  // Commit register writes on the access phase; reset restores factory values.
  always_ff @(posedge clk) begin
    if (rst) begin
      puk_code      <= {PUK_BYTES{ppe_pkg::PUK_DIGIT_RESET}};
      pin_try_limit <= ppe_pkg::PIN_TRIES_RESET;
      puk_try_limit <= ppe_pkg::PUK_TRIES_RESET;
    end else if (reg_write) begin
      case (reg_index)
        ppe_pkg::REG_PUK_CODE:      puk_code      <= pwdata[PUK_W-1:0];
        ppe_pkg::REG_PIN_TRY_LIMIT: pin_try_limit <= pwdata[3:0];
        ppe_pkg::REG_PUK_TRY_LIMIT: puk_try_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (reg_index)
      ppe_pkg::REG_PUK_CODE:      prdata = 64'(puk_code);
      ppe_pkg::REG_PIN_TRY_LIMIT: prdata = 64'(pin_try_limit);
      ppe_pkg::REG_PUK_TRY_LIMIT: prdata = 64'(puk_try_limit);
      default:                    prdata = 64'd0;
    endcase
  end

  // Front: take the command beat, decode action and length.
  ppe_front #(
    .PIN_BYTES (PIN_BYTES),
    .PUK_BYTES (PUK_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_entry (f_entry)
  );

  // Decouple decode from execution.
  ppe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // Back: apply the checks, update card state, hold the response beat.
  ppe_exec #(
    .PIN_BYTES (PIN_BYTES),
    .PUK_BYTES (PUK_BYTES)
  ) u_exec (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_entry       (q_entry),
    .puk_code      (puk_code),
    .pin_try_limit (pin_try_limit),
    .puk_try_limit (puk_try_limit),
    .rsp           (rsp)
  );

endmodule

[verif/tb_pin_guarded_purse_engine.sv]
// Self-checking testbench for the PIN-guarded purse engine.
module tb_pin_guarded_purse_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // Command lengths the engine expects for PIN_BYTES = 4, PUK_BYTES = 6.
  localparam logic [7:0] LEN_SHORT  = 8'd2;
  localparam logic [7:0] LEN_VERIFY = 8'd4;
  localparam logic [7:0] LEN_CHANGE = 8'd8;
  localparam logic [7:0] LEN_PUK    = 8'd10;

  // Unmapped register slot: writes must vanish, reads must return zero.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int PLAN_ROWS = 25;
  localparam int PRINT_CAP = 40;

  typedef struct {
    ppe_pkg::op_t op;
    logic [7:0]   len;
    logic [15:0]  ctr;
    logic [15:0]  amt;
    logic [31:0]  pin;
    logic [31:0]  pin_nw;
    logic [47:0]  puk;
  } card_cmd_t;

  typedef struct {
    ppe_pkg::status_t status;
    logic [4:0]       detail;
    logic [15:0]      data;
  } card_rsp_t;

  // One row of the directed table; typed rows carry their answer, the rest
  // are scored against the purse predictor.
  typedef struct {
    ppe_pkg::op_t     op;
    logic [7:0]       len;
    logic [15:0]      ctr;
    logic [15:0]      amt;
    logic [31:0]      pin;
    logic [31:0]      pin_nw;
    logic [47:0]      puk;
    bit               typed;
    ppe_pkg::status_t st;
    logic [4:0]       det;
    logic [15:0]      data;
  } card_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ppe_cmd_if cmd_ch ();
  ppe_rsp_if rsp_ch ();

  pin_guarded_purse_engine DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the card: configuration mirror and live state.
  logic [47:0] puk_code_cfg;
  logic [3:0]  pin_limit_cfg;
  logic [3:0]  puk_limit_cfg;
  logic [31:0] pin_store;
  logic [3:0]  pin_left;
  logic [3:0]  puk_left;
  logic        session_ok;
  logic [15:0] purse_balance;
  logic [15:0] replay_ctr;

  card_rsp_t owed_answers[$];   // answers predicted for accepted command beats
  card_rsp_t want;
  int        faults;
  int        rsp_hold;          // cycles the response side still holds off
  bit        quiet;             // no idling on either side while set
  bit        spend_puk;         // let PUK tries run down to zero

  // Directed table. It starts from the reset card: PIN 01020304, three PIN
  // tries, five PUK tries, PUK "999999", no session, empty purse.
  card_row_t plan [PLAN_ROWS] = '{
    '{ppe_pkg::OP_READ_BAL, LEN_SHORT, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_NOTVER, 0, 0},
    '{ppe_pkg::OP_READ_CTR, LEN_SHORT, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_READ_CTR, 0, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_LENGTH, 2, 0},
    '{ppe_pkg::OP_INVALID, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      48'hFFFFFFFFFFFF, 1, ppe_pkg::ST_LENGTH, 0, 0},
    '{ppe_pkg::OP_VERIFY, 3, 0, 0, 32'h01020304, 0, 0, 1, ppe_pkg::ST_LENGTH, 4, 0},
    '{ppe_pkg::OP_VERIFY, LEN_VERIFY, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_SECRET, 2, 0},
    '{ppe_pkg::OP_VERIFY, LEN_VERIFY, 0, 0, 32'hFFFFFFFF, 0, 0, 1,
      ppe_pkg::ST_SECRET, 1, 0},
    '{ppe_pkg::OP_CHANGE, LEN_CHANGE, 0, 0, 32'h01020305, 0, 0, 1,
      ppe_pkg::ST_BLOCKED, 0, 0},
    '{ppe_pkg::OP_VERIFY, LEN_VERIFY, 0, 0, 32'h01020304, 0, 0, 1,
      ppe_pkg::ST_BLOCKED, 0, 0},
    '{ppe_pkg::OP_CHANGE, LEN_CHANGE, 0, 0, 32'h01020304, 32'h0A0B0C0D, 0, 1,
      ppe_pkg::ST_BLOCKED, 0, 0},
    '{ppe_pkg::OP_PUK_RESET, 9, 0, 0, 0, 0, 48'h393939393939, 1,
      ppe_pkg::ST_LENGTH, 10, 0},
    '{ppe_pkg::OP_PUK_RESET, LEN_PUK, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_SECRET, 4, 0},
    '{ppe_pkg::OP_PUK_RESET, LEN_PUK, 0, 0, 0, 32'hFFFFFFFF, 48'h393939393939, 0,
      ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_CREDIT, LEN_SHORT, 1, 5, 0, 0, 0, 1, ppe_pkg::ST_REPLAY, 0, 0},
    '{ppe_pkg::OP_CREDIT, LEN_SHORT, 0, 16'hFFFF, 0, 0, 0, 0, ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_CREDIT, LEN_SHORT, 1, 1, 0, 0, 0, 1, ppe_pkg::ST_AMOUNT, 0, 0},
    '{ppe_pkg::OP_READ_BAL, LEN_SHORT, 0, 0, 0, 0, 0, 0, ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_DEBIT, 3, 2, 0, 0, 0, 0, 1, ppe_pkg::ST_LENGTH, 2, 0},
    '{ppe_pkg::OP_DEBIT, LEN_SHORT, 3, 16'hFFFF, 0, 0, 0, 0, ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_DEBIT, LEN_SHORT, 4, 1, 0, 0, 0, 1, ppe_pkg::ST_AMOUNT, 0, 0},
    '{ppe_pkg::OP_READ_CTR, LEN_SHORT, 0, 0, 0, 0, 0, 0, ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_CHANGE, LEN_CHANGE, 0, 0, 32'hFFFFFFFF, 0, 0, 0,
      ppe_pkg::ST_OK, 0, 0},
    '{ppe_pkg::OP_CHANGE, 7, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_LENGTH, 8, 0},
    '{ppe_pkg::OP_VERIFY, LEN_VERIFY, 0, 0, 32'h12345678, 0, 0, 1,
      ppe_pkg::ST_SECRET, 2, 0},
    '{ppe_pkg::OP_DEBIT, LEN_SHORT, 5, 0, 0, 0, 0, 1, ppe_pkg::ST_NOTVER, 0, 0}
  };

  // Length the engine wants for each action; zero for the unused code.
  function automatic logic [7:0] cmd_len(input ppe_pkg::op_t op);
    case (op)
      ppe_pkg::OP_VERIFY:    return LEN_VERIFY;
      ppe_pkg::OP_CHANGE:    return LEN_CHANGE;
      ppe_pkg::OP_PUK_RESET: return LEN_PUK;
      ppe_pkg::OP_INVALID:   return 8'd0;
      default:               return LEN_SHORT;
    endcase
  endfunction

  // Answer to a wrong secret once its try counter has been dropped.
  function automatic card_rsp_t miss_answer(input logic [3:0] left);
    card_rsp_t r;
    if (left == 4'd0) r = '{ppe_pkg::ST_BLOCKED, 5'd0, 16'd0};
    else r = '{ppe_pkg::ST_SECRET, {1'b0, left}, 16'd0};
    return r;
  endfunction

  // Purse predictor: apply one command to the card copy, return its answer.
  task automatic purse_step(input card_cmd_t c, output card_rsp_t r);
    logic [16:0] sum;
    r = '{ppe_pkg::ST_OK, 5'd0, 16'd0};
    case (c.op)
      ppe_pkg::OP_READ_BAL, ppe_pkg::OP_READ_CTR: begin
        if (c.op == ppe_pkg::OP_READ_BAL && !session_ok) r.status = ppe_pkg::ST_NOTVER;
        else if (c.len != LEN_SHORT) r = '{ppe_pkg::ST_LENGTH, LEN_SHORT[4:0], 16'd0};
        else r.data = (c.op == ppe_pkg::OP_READ_BAL) ? purse_balance : replay_ctr;
      end
      ppe_pkg::OP_CREDIT, ppe_pkg::OP_DEBIT: begin
        if (!session_ok) r.status = ppe_pkg::ST_NOTVER;
        else if (c.ctr != replay_ctr) r.status = ppe_pkg::ST_REPLAY;
        else begin
          // A matching counter advances even if a later check refuses the beat.
          replay_ctr = replay_ctr + 16'd1;
          sum = {1'b0, purse_balance} + {1'b0, c.amt};
          if (c.len != LEN_SHORT) r = '{ppe_pkg::ST_LENGTH, LEN_SHORT[4:0], 16'd0};
          else if (c.op == ppe_pkg::OP_CREDIT ? sum[16] : (c.amt > purse_balance))
            r.status = ppe_pkg::ST_AMOUNT;
          else if (c.op == ppe_pkg::OP_CREDIT) purse_balance = sum[15:0];
          else purse_balance = purse_balance - c.amt;
        end
      end
      ppe_pkg::OP_VERIFY, ppe_pkg::OP_CHANGE: begin
        if (pin_left == 4'd0) r.status = ppe_pkg::ST_BLOCKED;
        else if (c.len != cmd_len(c.op))
          r = '{ppe_pkg::ST_LENGTH, 5'(cmd_len(c.op)), 16'd0};
        else if (c.pin != pin_store) begin
          session_ok = 1'b0;
          pin_left = pin_left - 4'd1;
          r = miss_answer(pin_left);
        end else begin
          if (c.op == ppe_pkg::OP_CHANGE) pin_store = c.pin_nw;
          session_ok = 1'b1;
          pin_left = pin_limit_cfg;
        end
      end
      ppe_pkg::OP_PUK_RESET: begin
        // A blocked PIN does not stop this one; only spent PUK tries do.
        if (puk_left == 4'd0) r.status = ppe_pkg::ST_BLOCKED;
        else if (c.len != LEN_PUK) r = '{ppe_pkg::ST_LENGTH, LEN_PUK[4:0], 16'd0};
        else if (c.puk != puk_code_cfg) begin
          puk_left = puk_left - 4'd1;
          r = miss_answer(puk_left);
        end else begin
          pin_store = c.pin_nw;
          pin_left = pin_limit_cfg;
          puk_left = puk_limit_cfg;
          session_ok = 1'b1;
        end
      end
      default: r.status = ppe_pkg::ST_LENGTH;
    endcase
  endtask

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Response side: hold ready low for the drawn number of cycles per beat.
  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold = rsp_hold - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Response scoreboard: every accepted beat must match the oldest owed answer.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (owed_answers.size() == 0) begin
        if (faults < PRINT_CAP)
          $display("%0t: response beat with nothing owed: status %0d detail %0d data %h",
                   $time, rsp_ch.status, rsp_ch.detail, rsp_ch.read_data);
        faults++;
      end else begin
        want = owed_answers.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.detail !== want.detail ||
            rsp_ch.read_data !== want.data) begin
          if (faults < PRINT_CAP)
            $display("%0t: response mismatch: expected status %0d detail %0d data %h,",
                     $time, want.status, want.detail, want.data,
                     " got status %0d detail %0d data %h",
                     rsp_ch.status, rsp_ch.detail, rsp_ch.read_data);
          faults++;
        end
      end
      // Draw the hold-off before the next beat.
      rsp_hold = quiet ? 0 : $urandom_range(0, 12);
    end
  end

  // Present one command beat after a random gap, wait for it to be taken,
  // then predict its answer. Typed rows owe the answer from the table.
  task automatic send_beat(input card_cmd_t c, input bit typed, input card_rsp_t typed_r);
    card_rsp_t r;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid           <= 1'b1;
    cmd_ch.action          <= c.op;
    cmd_ch.length_byte     <= c.len;
    cmd_ch.replay_count_in <= c.ctr;
    cmd_ch.amount          <= c.amt;
    cmd_ch.pin_entered     <= c.pin;
    cmd_ch.pin_new         <= c.pin_nw;
    cmd_ch.puk_entered     <= c.puk;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    purse_step(c, r);
    owed_answers.push_back(typed ? typed_r : r);
  endtask

  // Drop valid and wait until every owed answer has come back, plus a margin.
  task automatic settle(input int margin);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [63:0] wdata,
                           output logic [63:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read every slot back and compare with the mirror; the spare slot reads zero.
  task automatic check_regs();
    logic [63:0] got;
    logic [63:0] want_v;
    for (int i = 0; i < 4; i++) begin
      apb_cycle(1'b0, 2'(i), 64'd0, got);
      case (2'(i))
        ppe_pkg::REG_PUK_CODE:      want_v = {16'd0, puk_code_cfg};
        ppe_pkg::REG_PIN_TRY_LIMIT: want_v = {60'd0, pin_limit_cfg};
        ppe_pkg::REG_PUK_TRY_LIMIT: want_v = {60'd0, puk_limit_cfg};
        default:                    want_v = 64'd0;
      endcase
      if (got !== want_v) begin
        if (faults < PRINT_CAP)
          $display("%0t: register %0d read mismatch: expected %h, got %h",
                   $time, i, want_v, got);
        faults++;
      end
    end
  endtask

  // Reprogram all registers with the engine idle, poke the spare slot too.
  task automatic configure(input logic [47:0] puk, input logic [3:0] pin_lim,
                           input logic [3:0] puk_lim);
    logic [63:0] unused;
    settle(4);
    apb_cycle(1'b1, ppe_pkg::REG_PUK_CODE, {16'd0, puk}, unused);
    puk_code_cfg = puk;
    apb_cycle(1'b1, ppe_pkg::REG_PIN_TRY_LIMIT, {60'd0, pin_lim}, unused);
    pin_limit_cfg = pin_lim;
    apb_cycle(1'b1, ppe_pkg::REG_PUK_TRY_LIMIT, {60'd0, puk_lim}, unused);
    puk_limit_cfg = puk_lim;
    apb_cycle(1'b1, REG_SPARE, {$urandom, $urandom}, unused);
    check_regs();
  endtask

  // Draw a mostly well-formed command from the current card state: right
  // length, live counter, stored PIN and PUK most of the time, with noise.
  task automatic draw_cmd(output card_cmd_t c);
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) c.op = ppe_pkg::OP_READ_BAL;
    else if (k < 32) c.op = ppe_pkg::OP_CREDIT;
    else if (k < 52) c.op = ppe_pkg::OP_DEBIT;
    else if (k < 62) c.op = ppe_pkg::OP_VERIFY;
    else if (k < 70) c.op = ppe_pkg::OP_CHANGE;
    else if (k < 80) c.op = ppe_pkg::OP_PUK_RESET;
    else if (k < 88) c.op = ppe_pkg::OP_READ_CTR;
    else c.op = ppe_pkg::op_t'($urandom_range(0, 7));
    // Steer towards regaining a session, by PUK when the PIN is blocked.
    if (!session_ok && $urandom_range(0, 2) == 0)
      c.op = (pin_left != 4'd0) ? ppe_pkg::OP_VERIFY : ppe_pkg::OP_PUK_RESET;
    c.len = ($urandom_range(0, 7) != 0) ? cmd_len(c.op) : 8'($urandom_range(0, 255));
    c.ctr = ($urandom_range(0, 7) != 0) ? replay_ctr : 16'($urandom);
    case ($urandom_range(0, 3))
      0:       c.amt = 16'($urandom);
      1:       c.amt = 16'($urandom_range(0, 255));
      // Exactly fill or empty the purse.
      2:       c.amt = (c.op == ppe_pkg::OP_CREDIT) ? ~purse_balance : purse_balance;
      // One past the limit.
      default: c.amt = (c.op == ppe_pkg::OP_CREDIT) ? ~purse_balance + 16'd1 :
                                                       purse_balance + 16'd1;
    endcase
    c.pin    = ($urandom_range(0, 6) != 0) ? pin_store : $urandom;
    c.pin_nw = ($urandom_range(0, 3) != 0) ? $urandom : pin_store;
    // Keep at least one PUK try in hand until the last phase spends them.
    if ((spend_puk || puk_left > 4'd1) && $urandom_range(0, 3) == 0)
      c.puk = 48'({$urandom, $urandom});
    else
      c.puk = puk_code_cfg;
  endtask

  task automatic run_random(input int count);
    card_cmd_t c;
    for (int i = 0; i < count; i++) begin
      // Switch idling off for roughly one stretch in four.
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      // Now and then hold the sender until the engine has answered everything.
      if ($urandom_range(0, 49) == 0) settle(0);
      draw_cmd(c);
      send_beat(c, 1'b0, '{ppe_pkg::ST_OK, 5'd0, 16'd0});
    end
  endtask

  initial begin : stimulus
    card_cmd_t c;
    // Drive every input to a known value and hold reset.
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.action          = '0;
    cmd_ch.length_byte     = '0;
    cmd_ch.replay_count_in = '0;
    cmd_ch.amount          = '0;
    cmd_ch.pin_entered     = '0;
    cmd_ch.pin_new         = '0;
    cmd_ch.puk_entered     = '0;
    rsp_ch.ready           = 1'b0;
    rsp_hold  = 0;
    quiet     = 1'b0;
    spend_puk = 1'b0;
    faults    = 0;

    // Card copy at reset.
    puk_code_cfg  = 48'h393939393939;
    pin_limit_cfg = 4'd3;
    puk_limit_cfg = 4'd5;
    pin_store     = 32'h01020304;
    pin_left      = 4'd3;
    puk_left      = 4'd5;
    session_ok    = 1'b0;
    purse_balance = 16'd0;
    replay_ctr    = 16'd0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers must come out of reset with their documented values.
    check_regs();

    // Walk the directed table: try counters, blocking, PUK recovery, replay,
    // overflow and underflow, lengths and the unused action code.
    foreach (plan[i]) begin
      c = '{plan[i].op, plan[i].len, plan[i].ctr, plan[i].amt,
            plan[i].pin, plan[i].pin_nw, plan[i].puk};
      send_beat(c, plan[i].typed, '{plan[i].st, plan[i].det, plan[i].data});
    end

    run_random(400);

    // Top of every range.
    configure(48'hFFFF_FFFF_FFFF, 4'd15, 4'd15);
    run_random(350);

    // Zero PUK, zero PIN tries restored (PIN stays blocked), one PUK try.
    configure(48'h0, 4'd0, 4'd1);
    run_random(300);

    configure(48'($urandom) | (48'($urandom) << 24), 4'd1, 4'd2);
    run_random(300);

    // Recover a session by PUK with idling off, then carry on randomly.
    quiet = 1'b1;
    c = '{ppe_pkg::OP_PUK_RESET, LEN_PUK, 16'd0, 16'd0, 32'd0, pin_store, puk_code_cfg};
    send_beat(c, 1'b0, '{ppe_pkg::ST_OK, 5'd0, 16'd0});
    run_random(100);

    // Last phase: zero PUK limit and PUK tries allowed to run out for good.
    configure(48'({$urandom, $urandom}), 4'd15, 4'd0);
    spend_puk = 1'b1;
    run_random(250);

    // Drain, allow the pipeline latency to pass, then report.
    settle(8);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[pin_guarded_purse_engine.f]
rtl/core/ppe_pkg.sv
rtl/core/ppe_channels.sv
rtl/core/ppe_front.sv
rtl/core/ppe_queue.sv
rtl/core/ppe_exec.sv
rtl/core/pin_guarded_purse_engine.sv
verif/tb_pin_guarded_purse_engine.sv
